[hw/rtl/mxt_pkg.sv]
`timescale 1ns / 1ps

package mxt_pkg;

  // Set geometry.
  localparam int KEY_BITS    = 32;
  localparam int DATA_W      = 32;
  localparam int MAX_MEMBERS = 1024;
  localparam int MAX_NODES   = 32768;

  // Derived widths.
  localparam int LINK_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int MEM_AW = $clog2(MAX_MEMBERS);
  localparam int HELD_W = $clog2(MAX_MEMBERS + 1);
  localparam int LVL_W  = $clog2(KEY_BITS);

  // One trie node: the child for a one bit and the child for a zero bit.
  typedef struct packed {
    logic [LINK_W-1:0] one;
    logic [LINK_W-1:0] zero;
  } links_t;

  localparam int LINKS_W = $bits(links_t);

  // A link names a child only if it is nonzero and already allocated.
  function automatic logic link_ok(input logic [LINK_W-1:0] link,
                                   input logic [CNT_W-1:0] used);
    return (link != '0) && (CNT_W'(link) < used);
  endfunction

endpackage

[hw/rtl/mxt_in_if.sv]
`timescale 1ns / 1ps

interface mxt_in_if;
  logic                       valid;
  logic                       ready;
  logic [mxt_pkg::DATA_W-1:0] value;
  logic                       last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

[hw/rtl/mxt_out_if.sv]
`timescale 1ns / 1ps

interface mxt_out_if;
  logic                       valid;
  logic                       ready;
  logic [mxt_pkg::DATA_W-1:0] max_xor;
  logic                       dropped;

  modport source (output valid, output max_xor, output dropped, input ready);
  modport sink (input valid, input max_xor, input dropped, output ready);
endinterface

[hw/rtl/mxt_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module mxt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/max_xor_pair_trie.sv]
`timescale 1ns / 1ps

// Largest XOR of any two members of a set. Members arrive one word at a time
// and each is stored and inserted most significant bit first into a binary
// trie in node memory; the word flagged last starts the search, which walks
// every stored member down the trie preferring the opposite bit and returns
// the best XOR as one result word, after which the block is ready for a new
// set. An insert accepts the word, then walks one trie level per step as the
// single read port of the node memory is read once per level; no new word is
// taken until the insert is done. For each stored member the search reads the
// member buffer, then does one node read per level, and the result waits in
// the output register until taken. No clearing pass is needed: the root links
// live in flip-flops and every node below the root but a leaf is written as
// its branch is built; leaf links are never used. Members past 1024, or once
// fewer than 32 free nodes remain, are dropped and reported with the result.
module max_xor_pair_trie (
  input  logic             clk,
  input  logic             rst,
  mxt_in_if.sink           members,
  mxt_out_if.source        result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_CHAIN,
    S_FETCH,
    S_KEY,
    S_SRCH,
    S_OUT
  } state_t;

  state_t                         state;
  logic [mxt_pkg::KEY_BITS-1:0]   key;
  logic [mxt_pkg::KEY_BITS-1:0]   acc;
  logic [mxt_pkg::KEY_BITS-1:0]   best;
  logic [mxt_pkg::LVL_W-1:0]      lvl;
  logic [mxt_pkg::LINK_W-1:0]     cur;
  logic                           cur_root;
  logic                           last_r;
  logic                           overflow;
  logic [mxt_pkg::CNT_W-1:0]      nodes_used;
  logic [mxt_pkg::HELD_W-1:0]     held;
  logic [mxt_pkg::HELD_W-1:0]     idx;
  mxt_pkg::links_t                root_links;

  logic                           member_we;
  logic [mxt_pkg::MEM_AW-1:0]     member_waddr;
  logic [mxt_pkg::KEY_BITS-1:0]   member_rdata;
  logic                           node_we;
  logic [mxt_pkg::LINK_W-1:0]     node_waddr;
  mxt_pkg::links_t                node_wdata;
  logic [mxt_pkg::LINK_W-1:0]     node_raddr;
  mxt_pkg::links_t                node_rdata;

  mxt_pkg::links_t                cur_links;
  logic [mxt_pkg::LINK_W-1:0]     new_link;
  logic                           accept;
  logic                           drop;
  logic                           ins_bit;
  logic [mxt_pkg::LINK_W-1:0]     ins_child;
  logic                           ins_hit;
  logic                           want;
  logic [mxt_pkg::LINK_W-1:0]     opp;
  logic [mxt_pkg::LINK_W-1:0]     same;
  logic                           opp_ok;
  logic                           same_ok;
  logic [mxt_pkg::KEY_BITS-1:0]   srch_acc;
  logic                           srch_end;
  logic                           last_member;

  function automatic logic [mxt_pkg::KEY_BITS-1:0] key_in_word();
    return members.value[mxt_pkg::KEY_BITS-1:0];
  endfunction

  // Member buffer and node memory.
  mxt_ram #(
    .WIDTH (mxt_pkg::KEY_BITS),
    .DEPTH (mxt_pkg::MAX_MEMBERS)
  ) u_member_ram (
    .clk   (clk),
    .we    (member_we),
    .waddr (member_waddr),
    .wdata (key_in_word()),
    .raddr (idx[mxt_pkg::MEM_AW-1:0]),
    .rdata (member_rdata)
  );

  mxt_ram #(
    .WIDTH (mxt_pkg::LINKS_W),
    .DEPTH (mxt_pkg::MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Handshake and capacity check for an incoming word.
  assign members.ready = (state == S_IDLE);
  assign accept        = members.valid && members.ready;
  assign drop          = (held >= mxt_pkg::HELD_W'(mxt_pkg::MAX_MEMBERS)) ||
                         (mxt_pkg::SUM_W'(nodes_used) + mxt_pkg::SUM_W'(mxt_pkg::KEY_BITS) >
                          mxt_pkg::SUM_W'(mxt_pkg::MAX_NODES));
  assign member_we     = accept && !drop;
  assign member_waddr  = held[mxt_pkg::MEM_AW-1:0];

  // Links of the node under the walk: root from flip-flops, others from memory.
  assign cur_links = cur_root ? root_links : node_rdata;
  assign new_link  = nodes_used[mxt_pkg::LINK_W-1:0];

  // Insert step: follow the key bit, allocate where the child is missing.
  assign ins_bit   = key[lvl];
  assign ins_child = ins_bit ? cur_links.one : cur_links.zero;
  assign ins_hit   = mxt_pkg::link_ok(ins_child, nodes_used);

  // Search step: prefer the child with the opposite bit.
  assign want        = ~key[lvl];
  assign opp         = want ? cur_links.one : cur_links.zero;
  assign same        = want ? cur_links.zero : cur_links.one;
  assign opp_ok      = mxt_pkg::link_ok(opp, nodes_used);
  assign same_ok     = mxt_pkg::link_ok(same, nodes_used);
  assign srch_acc    = opp_ok ? (acc | (mxt_pkg::KEY_BITS'(1) << lvl)) : acc;
  assign srch_end    = (lvl == '0) || (!opp_ok && !same_ok);
  assign last_member = ((idx + mxt_pkg::HELD_W'(1)) == held);

  // Node memory ports.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cur;
    node_wdata = cur_links;
    node_raddr = '0;
    unique case (state)
      S_INS_WALK: begin
        node_raddr = ins_child;
        if (!ins_hit && !cur_root) begin
          node_we = 1'b1;
          if (ins_bit) begin
            node_wdata.one = new_link;
          end else begin
            node_wdata.zero = new_link;
          end
        end
      end
      S_INS_CHAIN: begin
        node_we         = 1'b1;
        node_wdata.one  = ins_bit ? new_link : '0;
        node_wdata.zero = ins_bit ? '0 : new_link;
      end
      S_SRCH: begin
        node_raddr = opp_ok ? opp : same;
      end
      default: begin
        node_raddr = '0;
      end
    endcase
  end

  // Result word.
  assign result.valid   = (state == S_OUT);
  assign result.max_xor = mxt_pkg::DATA_W'(best);
  assign result.dropped = overflow;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= mxt_pkg::CNT_W'(1);
      held       <= '0;
      best       <= '0;
      overflow   <= 1'b0;
      root_links <= '0;
      cur_root   <= 1'b1;
      idx        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key    <= key_in_word();
            last_r <= members.last;
            if (drop) begin
              overflow <= 1'b1;
              if (members.last) begin
                idx   <= '0;
                best  <= '0;
                state <= (held == '0) ? S_OUT : S_FETCH;
              end
            end else begin
              held     <= held + mxt_pkg::HELD_W'(1);
              cur_root <= 1'b1;
              lvl      <= mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
              state    <= S_INS_WALK;
            end
          end
        end

        S_INS_WALK: begin
          cur_root <= 1'b0;
          if (ins_hit) begin
            cur <= ins_child;
          end else begin
            if (cur_root) begin
              if (ins_bit) begin
                root_links.one <= new_link;
              end else begin
                root_links.zero <= new_link;
              end
            end
            nodes_used <= nodes_used + mxt_pkg::CNT_W'(1);
            cur        <= new_link;
          end
          if (lvl == '0) begin
            idx   <= '0;
            best  <= '0;
            state <= last_r ? S_FETCH : S_IDLE;
          end else begin
            lvl <= lvl - mxt_pkg::LVL_W'(1);
            if (!ins_hit) begin
              state <= S_INS_CHAIN;
            end
          end
        end

        // Fresh branch: every node links straight to the next one allocated.
        S_INS_CHAIN: begin
          nodes_used <= nodes_used + mxt_pkg::CNT_W'(1);
          cur        <= new_link;
          if (lvl == '0) begin
            idx   <= '0;
            best  <= '0;
            state <= last_r ? S_FETCH : S_IDLE;
          end else begin
            lvl <= lvl - mxt_pkg::LVL_W'(1);
          end
        end

        S_FETCH: begin
          state <= S_KEY;
        end

        S_KEY: begin
          key      <= member_rdata;
          acc      <= '0;
          lvl      <= mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
          cur_root <= 1'b1;
          state    <= S_SRCH;
        end

        S_SRCH: begin
          cur_root <= 1'b0;
          cur      <= opp_ok ? opp : same;
          acc      <= srch_acc;
          lvl      <= lvl - mxt_pkg::LVL_W'(1);
          if (srch_end) begin
            if (srch_acc > best) begin
              best <= srch_acc;
            end
            if (last_member) begin
              state <= S_OUT;
            end else begin
              idx   <= idx + mxt_pkg::HELD_W'(1);
              state <= S_FETCH;
            end
          end
        end

        // Result taken: start a new set.
        S_OUT: begin
          if (result.ready) begin
            nodes_used <= mxt_pkg::CNT_W'(1);
            held       <= '0;
            best       <= '0;
            overflow   <= 1'b0;
            root_links <= '0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The member buffer never holds more than its capacity.
  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    held <= mxt_pkg::HELD_W'(mxt_pkg::MAX_MEMBERS))
    else $error("member count beyond capacity");

  // A dropped word leaves the member count unchanged.
  a_drop_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && drop) |=> (held == $past(held)))
    else $error("dropped word changed the member count");

  // Node writes never land on the root entry.
  a_no_root_write: assert property (@(posedge clk) disable iff (rst)
    node_we |-> (node_waddr != '0))
    else $error("node memory write to the root entry");

  // The search only visits stored members.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SRCH) || (state == S_KEY)) |-> (idx < held))
    else $error("search index past the stored members");

endmodule

[sim/max_xor_pair_trie_test.sv]
`timescale 1ns / 1ps

module max_xor_pair_trie_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 200;
  localparam int BIG_SET     = mxt_pkg::MAX_MEMBERS + 2;

  typedef struct packed {
    logic [mxt_pkg::DATA_W-1:0] value;
    logic                       last;
  } member_word_t;

  typedef struct packed {
    logic [mxt_pkg::DATA_W-1:0] max_xor;
    logic                       dropped;
  } best_word_t;

  logic clk;
  logic rst;

  mxt_in_if  members_ch ();
  mxt_out_if result_ch ();

  max_xor_pair_trie dut (
    .clk     (clk),
    .rst     (rst),
    .members (members_ch),
    .result  (result_ch)
  );

  // Words waiting to be offered, and results owed by the block.
  member_word_t pending_members[$];
  best_word_t   expected_best[$];

  // Shadow copy of the set: member buffer and trie links.
  logic [mxt_pkg::DATA_W-1:0] held_members [mxt_pkg::MAX_MEMBERS];
  int unsigned                trie_links [mxt_pkg::MAX_NODES][2];
  int unsigned                trie_nodes;
  int unsigned                held_count;
  bit                         set_overflow;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_go        = 1'b0;
  logic hold_off      = 1'b0;
  int  mismatches     = 0;
  int  members_sent   = 0;
  int  sets_checked   = 0;
  int  sets_dropped   = 0;
  int  cycle_count    = 0;

  // Empty the shadow set, keeping only a root with no children.
  function automatic void clear_shadow_set();
    trie_links[0][0] = 0;
    trie_links[0][1] = 0;
    trie_nodes   = 1;
    held_count   = 0;
    set_overflow = 1'b0;
  endfunction

  // Walk a key into the trie, allocating nodes where a path is missing.
  function automatic void trie_insert(logic [mxt_pkg::DATA_W-1:0] key);
    int unsigned node;
    int unsigned nxt;
    int          b;
    node = 0;
    for (int j = mxt_pkg::KEY_BITS - 1; j >= 0; j--) begin
      b   = key[j];
      nxt = trie_links[node][b];
      if (nxt == 0 || nxt >= trie_nodes) begin
        nxt = trie_nodes;
        trie_nodes++;
        trie_links[nxt][0] = 0;
        trie_links[nxt][1] = 0;
        trie_links[node][b] = nxt;
      end
      node = nxt;
    end
  endfunction

  // Best XOR one key can reach, taking the opposite bit wherever it exists.
  function automatic logic [mxt_pkg::DATA_W-1:0] best_partner_xor(
    logic [mxt_pkg::DATA_W-1:0] key
  );
    int unsigned                node;
    int unsigned                opp;
    int unsigned                same;
    int                         want;
    logic [mxt_pkg::DATA_W-1:0] acc;
    node = 0;
    acc  = '0;
    for (int j = mxt_pkg::KEY_BITS - 1; j >= 0; j--) begin
      want = key[j] ^ 1'b1;
      opp  = trie_links[node][want];
      same = trie_links[node][want ^ 1];
      if (opp != 0 && opp < trie_nodes) begin
        acc[j] = 1'b1;
        node   = opp;
      end else if (same != 0 && same < trie_nodes) begin
        node = same;
      end else begin
        break;
      end
    end
    return acc;
  endfunction

  // Take one accepted word; the last word of a set yields the expected result.
  function automatic void absorb_member(logic [mxt_pkg::DATA_W-1:0] value, logic last);
    best_word_t                 res;
    logic [mxt_pkg::DATA_W-1:0] x;
    if (held_count >= mxt_pkg::MAX_MEMBERS ||
        trie_nodes + mxt_pkg::KEY_BITS > mxt_pkg::MAX_NODES) begin
      set_overflow = 1'b1;
    end else begin
      held_members[held_count] = value;
      held_count++;
      trie_insert(value);
    end
    if (last) begin
      res.max_xor = '0;
      for (int unsigned i = 0; i < held_count; i++) begin
        x = best_partner_xor(held_members[i]);
        if (x > res.max_xor) begin
          res.max_xor = x;
        end
      end
      res.dropped = set_overflow;
      expected_best.push_back(res);
      clear_shadow_set();
    end
  endfunction

  function automatic void queue_member(logic [mxt_pkg::DATA_W-1:0] value, logic last);
    member_word_t w;
    w.value = value;
    w.last  = last;
    pending_members.push_back(w);
  endfunction

  // One member near a base pattern, or from a few other value families.
  function automatic logic [mxt_pkg::DATA_W-1:0] pick_member(
    logic [mxt_pkg::DATA_W-1:0] base
  );
    logic [mxt_pkg::DATA_W-1:0] low_mask;
    low_mask = (mxt_pkg::DATA_W'(1) << $urandom_range(mxt_pkg::DATA_W - 1)) - 1;
    case ($urandom_range(5))
      0: return $urandom();
      1: return base ^ ($urandom() & low_mask);
      2: return mxt_pkg::DATA_W'($urandom_range(255));
      3: return {mxt_pkg::DATA_W{1'b1}} ^ mxt_pkg::DATA_W'($urandom_range(255));
      4: return mxt_pkg::DATA_W'(1) << $urandom_range(mxt_pkg::DATA_W - 1);
      default: return base;
    endcase
  endfunction

  // Queue whole sets of mostly small size until the budget is spent.
  task automatic queue_sets(int budget);
    int                         count;
    int                         size;
    logic [mxt_pkg::DATA_W-1:0] base;
    count = 0;
    while (count < budget) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      base = $urandom();
      for (int k = 0; k < size; k++) begin
        queue_member(pick_member(base), k == size - 1);
      end
      count += size;
    end
  endtask

  // The sender pauses here until every result owed has been taken.
  task automatic wait_drained();
    while (pending_members.size() != 0 || members_ch.valid || expected_best.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Reset asserted at the start and then released, with an empty shadow set.
  initial begin
    rst = 1'b1;
    clear_shadow_set();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Member driver: offers queued words with random gaps.
  always @(posedge clk) begin : member_driver
    member_word_t nxt;
    if (rst) begin
      members_ch.valid <= 1'b0;
      members_ch.value <= '0;
      members_ch.last  <= 1'b0;
    end else begin
      if (members_ch.valid && members_ch.ready) begin
        absorb_member(members_ch.value, members_ch.last);
        members_sent++;
      end
      if (!members_ch.valid || members_ch.ready) begin
        if (pending_members.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_members.pop_front();
          members_ch.valid <= 1'b1;
          members_ch.value <= nxt.value;
          members_ch.last  <= nxt.last;
        end else begin
          members_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken word against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    best_word_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_best.size() == 0) begin
          $error("unexpected result word: max_xor %h dropped %b",
                 result_ch.max_xor, result_ch.dropped);
          mismatches++;
        end else begin
          want = expected_best.pop_front();
          sets_checked++;
          if (want.dropped) begin
            sets_dropped++;
          end
          if (result_ch.max_xor !== want.max_xor) begin
            $error("max_xor mismatch: expected %h, got %h", want.max_xor, result_ch.max_xor);
            mismatches++;
          end
          if (result_ch.dropped !== want.dropped) begin
            $error("dropped mismatch: expected %b, got %b", want.dropped, result_ch.dropped);
            mismatches++;
          end
        end
      end
      result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    logic [mxt_pkg::DATA_W-1:0] v;
    // Single member, full-range pair, duplicates and a few crafted sets.
    queue_member(32'h0000_0000, 1'b1);
    queue_member(32'h0000_0000, 1'b0);
    queue_member(32'hFFFF_FFFF, 1'b1);
    queue_member(32'hFFFF_FFFF, 1'b0);
    queue_member(32'hFFFF_FFFF, 1'b1);
    queue_member(32'h8000_0000, 1'b0);
    queue_member(32'h7FFF_FFFF, 1'b1);
    queue_member(32'h0000_0001, 1'b0);
    queue_member(32'h0000_0002, 1'b0);
    queue_member(32'h0000_0003, 1'b1);
    queue_member(32'h0000_0000, 1'b0);
    queue_member(32'h0000_0001, 1'b0);
    queue_member(32'h8000_0000, 1'b1);
    queue_member(32'hAAAA_AAAA, 1'b0);
    queue_member(32'h5555_5555, 1'b0);
    queue_member(32'hAAAA_AAAB, 1'b1);
    queue_member(32'h1234_5678, 1'b0);
    queue_member(32'h1234_5679, 1'b0);
    queue_member(32'h1234_567A, 1'b0);
    queue_member(32'h1234_5670, 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (p == 0) begin
        // Several sets back to back while the receiver holds off.
        queue_sets(50);
        hold_go = 1'b1;
        wait_drained();
        // Full member buffer: the members past capacity would raise the top
        // bit of the best XOR if they were wrongly kept, and the last is one.
        for (int k = 0; k < BIG_SET; k++) begin
          if (k < mxt_pkg::MAX_MEMBERS) begin
            v = mxt_pkg::DATA_W'($urandom()) >> 1;
          end else begin
            v = {mxt_pkg::DATA_W{1'b1}} ^ mxt_pkg::DATA_W'($urandom_range(15));
          end
          queue_member(v, k == BIG_SET - 1);
        end
      end else begin
        queue_sets(250);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d member words sent, %0d sets checked, %0d with dropped members",
             members_sent, sets_checked, sets_dropped);
    $display("summary: idle phases none, sender 86%%, receiver 86%%, both 34%%, one long hold-off");
    if (mismatches == 0 && expected_best.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mxt_pkg.sv
hw/rtl/mxt_in_if.sv
hw/rtl/mxt_out_if.sv
hw/rtl/mxt_ram.sv
hw/rtl/max_xor_pair_trie.sv
sim/max_xor_pair_trie_test.sv
